// ===== rtl/halfband_decimator_q15_defines.svh =====
// assertion macros shared by the half-band decimator rtl
// no dependencies
`ifndef HALFBAND_DECIMATOR_Q15_DEFINES_SVH
`define HALFBAND_DECIMATOR_Q15_DEFINES_SVH

// condition holds in the same cycle
`define HBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("halfband decimator assertion failed");

// condition holds in the following cycle
`define HBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("halfband decimator assertion failed");

`endif

// ===== rtl/hbd_pkg.sv =====
// shared constants and types for the half-band decimator
// no dependencies
package hbd_pkg;

   localparam int TAP_COUNT  = 15;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int PRE_W      = SAMPLE_W + 1;
   localparam int PROD_W     = PRE_W + COEF_W;
   localparam int ACC_W      = PROD_W + 3;
   localparam int FRAC_BITS  = 15;
   localparam int COEF_COUNT = 5;
   localparam int INDEX_W    = 3;
   localparam int WARM_W     = 3;

   localparam logic [WARM_W-1:0] WARM_DONE = WARM_W'(7);
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << 14);

   localparam logic signed [COEF_W-1:0] OUTER_RESET  = -16'sd108;
   localparam logic signed [COEF_W-1:0] FAR_RESET    = 16'sd1800;
   localparam logic signed [COEF_W-1:0] MID_RESET    = -16'sd500;
   localparam logic signed [COEF_W-1:0] NEAR_RESET   = 16'sd7000;
   localparam logic signed [COEF_W-1:0] CENTRE_RESET = 16'sd16384;

   typedef enum logic [INDEX_W-1:0] {
      REG_OUTER  = 3'd0,
      REG_FAR    = 3'd1,
      REG_MID    = 3'd2,
      REG_NEAR   = 3'd3,
      REG_CENTRE = 3'd4
   } reg_index_type;

endpackage

// ===== rtl/hbd_tap_cell.sv =====
// one delay line cell: holds a sample and passes it to its neighbor
// depends on hbd_pkg
module hbd_tap_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift,
   input  logic signed [hbd_pkg::SAMPLE_W-1:0] sample_in,
   output logic signed [hbd_pkg::SAMPLE_W-1:0] sample_out
);

   logic signed [hbd_pkg::SAMPLE_W-1:0] sample_ff;
   logic signed [hbd_pkg::SAMPLE_W-1:0] sample_in_mux;

   assign sample_in_mux = shift ? sample_in : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_mux;
      end
   end

   assign sample_out = sample_ff;

endmodule

// ===== rtl/hbd_pair_mac.sv =====
// symmetric pair pre-add and coefficient multiply, registered product
// depends on hbd_pkg
module hbd_pair_mac (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [hbd_pkg::SAMPLE_W-1:0] tap_a,
   input  logic signed [hbd_pkg::SAMPLE_W-1:0] tap_b,
   input  logic signed [hbd_pkg::COEF_W-1:0]   coef,
   output logic signed [hbd_pkg::PROD_W-1:0]   product
);

   logic signed [hbd_pkg::PRE_W-1:0]  pre_sum;
   logic signed [hbd_pkg::PROD_W-1:0] product_in;
   logic signed [hbd_pkg::PROD_W-1:0] product_ff;

   assign pre_sum    = hbd_pkg::PRE_W'(tap_a) + hbd_pkg::PRE_W'(tap_b);
   assign product_in = pre_sum * coef;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== rtl/halfband_decimator_q15.sv =====
// top level of the 15-tap half-band decimator by two, q15 arithmetic
// depends on hbd_pkg, hbd_tap_cell, hbd_pair_mac and the defines header
//
// Takes one signed sample per cycle, with no gaps required between
// transactions. After the first seven samples, every second sample yields one
// rounded, saturated output transaction, registered through the product, sum and
// rounding stages. The shifting delay line takes one sample per clock; the five
// coefficient products, their sum and the rounding each occupy one register
// stage. The whole pipeline stalls only while a finished result waits on
// rsp_ready, and then req_ready is low. Coefficient registers are written through
// the csr port; indexes five to seven are ignored.
`include "halfband_decimator_q15_defines.svh"

module halfband_decimator_q15 #(
   parameter int TAP_COUNT = hbd_pkg::TAP_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [hbd_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [hbd_pkg::SAMPLE_W-1:0] rsp_filtered_out,
   input  logic                                csr_we,
   input  logic [hbd_pkg::INDEX_W-1:0]         csr_index,
   input  logic [hbd_pkg::COEF_W-1:0]          csr_wdata
);

   localparam int CENTRE = (TAP_COUNT - 1) / 2;
   localparam int SHIFT_W = hbd_pkg::ACC_W - hbd_pkg::FRAC_BITS;

   logic signed [hbd_pkg::SAMPLE_W-1:0] taps [TAP_COUNT];
   logic signed [hbd_pkg::COEF_W-1:0]   coef_ff [hbd_pkg::COEF_COUNT];
   logic signed [hbd_pkg::PROD_W-1:0]   prod [hbd_pkg::COEF_COUNT];

   logic                               advance;
   logic                               accept;
   logic                               emit;
   logic [hbd_pkg::WARM_W-1:0]         warm_ff, warm_in;
   logic                               phase_ff, phase_in;
   logic                               v0_ff, v0_in;
   logic                               v1_ff;
   logic                               v2_ff;
   logic                               rsp_valid_ff;
   logic signed [hbd_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [SHIFT_W-1:0]          shifted;
   logic signed [hbd_pkg::SAMPLE_W-1:0] out_ff, out_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[hbd_pkg::REG_OUTER]  <= hbd_pkg::OUTER_RESET;
         coef_ff[hbd_pkg::REG_FAR]    <= hbd_pkg::FAR_RESET;
         coef_ff[hbd_pkg::REG_MID]    <= hbd_pkg::MID_RESET;
         coef_ff[hbd_pkg::REG_NEAR]   <= hbd_pkg::NEAR_RESET;
         coef_ff[hbd_pkg::REG_CENTRE] <= hbd_pkg::CENTRE_RESET;
      end else if (csr_we) begin
         case (hbd_pkg::reg_index_type'(csr_index))
            hbd_pkg::REG_OUTER:  coef_ff[hbd_pkg::REG_OUTER]  <= csr_wdata;
            hbd_pkg::REG_FAR:    coef_ff[hbd_pkg::REG_FAR]    <= csr_wdata;
            hbd_pkg::REG_MID:    coef_ff[hbd_pkg::REG_MID]    <= csr_wdata;
            hbd_pkg::REG_NEAR:   coef_ff[hbd_pkg::REG_NEAR]   <= csr_wdata;
            hbd_pkg::REG_CENTRE: coef_ff[hbd_pkg::REG_CENTRE] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // delay line
   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
      logic signed [hbd_pkg::SAMPLE_W-1:0] cell_in;
      if (k == 0) begin : g_head
         assign cell_in = req_sample_in;
      end else begin : g_body
         assign cell_in = taps[k-1];
      end
      hbd_tap_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (accept),
         .sample_in  (cell_in),
         .sample_out (taps[k])
      );
   end

   // warmup and decimation phase
   always_comb begin
      warm_in  = warm_ff;
      phase_in = phase_ff;
      emit     = 1'b0;
      if (accept) begin
         if (warm_ff != hbd_pkg::WARM_DONE) begin
            warm_in = warm_ff + 1'b1;
         end else if (phase_ff) begin
            phase_in = 1'b0;
         end else begin
            phase_in = 1'b1;
            emit     = 1'b1;
         end
      end
   end

   assign v0_in = emit;

   // products from the state left by the last sample
   hbd_pair_mac u_mac_outer (
      .clock (clock), .enable (advance),
      .tap_a (taps[CENTRE-7]), .tap_b (taps[CENTRE+7]),
      .coef  (coef_ff[hbd_pkg::REG_OUTER]), .product (prod[hbd_pkg::REG_OUTER])
   );
   hbd_pair_mac u_mac_far (
      .clock (clock), .enable (advance),
      .tap_a (taps[CENTRE-5]), .tap_b (taps[CENTRE+5]),
      .coef  (coef_ff[hbd_pkg::REG_FAR]), .product (prod[hbd_pkg::REG_FAR])
   );
   hbd_pair_mac u_mac_mid (
      .clock (clock), .enable (advance),
      .tap_a (taps[CENTRE-3]), .tap_b (taps[CENTRE+3]),
      .coef  (coef_ff[hbd_pkg::REG_MID]), .product (prod[hbd_pkg::REG_MID])
   );
   hbd_pair_mac u_mac_near (
      .clock (clock), .enable (advance),
      .tap_a (taps[CENTRE-1]), .tap_b (taps[CENTRE+1]),
      .coef  (coef_ff[hbd_pkg::REG_NEAR]), .product (prod[hbd_pkg::REG_NEAR])
   );
   hbd_pair_mac u_mac_centre (
      .clock (clock), .enable (advance),
      .tap_a (taps[CENTRE]), .tap_b ('0),
      .coef  (coef_ff[hbd_pkg::REG_CENTRE]), .product (prod[hbd_pkg::REG_CENTRE])
   );

   assign acc_in = hbd_pkg::ACC_W'(prod[hbd_pkg::REG_OUTER])
                 + hbd_pkg::ACC_W'(prod[hbd_pkg::REG_FAR])
                 + hbd_pkg::ACC_W'(prod[hbd_pkg::REG_MID])
                 + hbd_pkg::ACC_W'(prod[hbd_pkg::REG_NEAR])
                 + hbd_pkg::ACC_W'(prod[hbd_pkg::REG_CENTRE])
                 + hbd_pkg::ROUND_BIAS;

   // round and saturate
   assign shifted = acc_ff[hbd_pkg::ACC_W-1:hbd_pkg::FRAC_BITS];

   always_comb begin
      if (shifted > SHIFT_W'(32767)) begin
         out_in = 16'sh7fff;
      end else if (shifted < -SHIFT_W'(32768)) begin
         out_in = 16'sh8000;
      end else begin
         out_in = shifted[hbd_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff <= acc_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff      <= '0;
         phase_ff     <= 1'b0;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         warm_ff  <= warm_in;
         phase_ff <= phase_in;
         if (advance) begin
            v0_ff        <= v0_in;
            v1_ff        <= v0_ff;
            v2_ff        <= v1_ff;
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_out = out_ff;

   `HBD_ASSERT_NOW(a_phase_after_warmup, clock, reset, warm_ff != hbd_pkg::WARM_DONE, !phase_ff)
   `HBD_ASSERT_NEXT(a_warmup_silent, clock, reset, accept && warm_ff != hbd_pkg::WARM_DONE, !v0_ff)
   `HBD_ASSERT_NEXT(a_odd_phase_silent, clock, reset, accept && phase_ff, !v0_ff)
   `HBD_ASSERT_NOW(a_gap_mult_sum, clock, reset, v1_ff, !v2_ff)
   `HBD_ASSERT_NOW(a_gap_sum_out, clock, reset, v2_ff, !rsp_valid_ff)

endmodule

// ===== test/halfband_decimator_q15_tb.sv =====
// self-checking testbench for the 15-tap half-band decimator by two
// depends on hbd_pkg and the halfband_decimator_q15 rtl
// a bit-true filter model predicts each output transaction; random idling on both sides
module halfband_decimator_q15_tb;
   import hbd_pkg::*;

   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 20;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 110;
   localparam int CENTRE        = (TAP_COUNT - 1) / 2;
   localparam int MAX_PRINTED   = 50;

   localparam logic [INDEX_W-1:0] IDX_SPARE_FIRST = INDEX_W'(COEF_COUNT);
   localparam logic [INDEX_W-1:0] IDX_SPARE_LAST  = '1;

   localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
   localparam longint OUT_MAX = longint'(S_MAX);
   localparam longint OUT_MIN = longint'(S_MIN);

   typedef enum int {
      COEFS_DEFAULT,
      COEFS_EXTREME,
      COEFS_RANDOM,
      COEFS_SMALL,
      COEFS_SINGLE,
      COEFS_ALL_MAX,
      COEFS_ALL_MIN
   } coef_set_t;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_MASK,
      READY_RUNS
   } ready_mode_t;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [SAMPLE_W-1:0]   req_sample_in = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_filtered_out;
   logic                         csr_we = 1'b0;
   logic [INDEX_W-1:0]           csr_index = '0;
   logic [COEF_W-1:0]            csr_wdata = '0;

   // filter model state
   logic signed [SAMPLE_W-1:0]   taps [TAP_COUNT];
   logic signed [COEF_W-1:0]     coef_model [COEF_COUNT];
   logic [WARM_W-1:0]            warm_count;
   logic                         odd_phase;
   logic [SAMPLE_W-1:0]          pending_outputs [$];

   int                           mismatch_count = 0;
   int                           idle_cycles = 0;
   int                           sender_gap_max = 0;
   int                           burst_left = 0;

   ready_mode_t                  ready_mode = READY_ALWAYS;
   logic [7:0]                   ready_mask = 8'hff;
   logic [2:0]                   ready_step = '0;
   logic                         ready_hold = 1'b0;
   int                           ready_run = 0;

   halfband_decimator_q15 i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_filtered_out (rsp_filtered_out),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                  input logic [SAMPLE_W-1:0] want);
      if (mismatch_count < MAX_PRINTED) begin
         $display("mismatch at %0t: %s, got %0d, wanted %0d", $realtime, what,
                  $signed(got), $signed(want));
      end
      mismatch_count++;
   endtask

   function automatic void run_filter_model(input logic signed [SAMPLE_W-1:0] value);
      longint acc;
      for (int i = TAP_COUNT - 1; i > 0; i--) taps[i] = taps[i - 1];
      taps[0] = value;
      if (warm_count < WARM_DONE) begin
         warm_count++;
         return;
      end
      if (odd_phase) begin
         odd_phase = 1'b0;
         return;
      end
      odd_phase = 1'b1;
      acc = longint'(coef_model[REG_CENTRE]) * longint'(taps[CENTRE]);
      acc += longint'(coef_model[REG_NEAR])
             * (longint'(taps[CENTRE - 1]) + longint'(taps[CENTRE + 1]));
      acc += longint'(coef_model[REG_MID])
             * (longint'(taps[CENTRE - 3]) + longint'(taps[CENTRE + 3]));
      acc += longint'(coef_model[REG_FAR])
             * (longint'(taps[CENTRE - 5]) + longint'(taps[CENTRE + 5]));
      acc += longint'(coef_model[REG_OUTER])
             * (longint'(taps[CENTRE - 7]) + longint'(taps[CENTRE + 7]));
      acc += longint'(ROUND_BIAS);
      acc = acc >>> FRAC_BITS;
      if (acc > OUT_MAX) acc = OUT_MAX;
      if (acc < OUT_MIN) acc = OUT_MIN;
      pending_outputs.push_back(SAMPLE_W'(acc));
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return S_MAX;
         1: return S_MIN;
         2: return '0;
         3: return '1;
         default: return SAMPLE_W'(1);
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int style;
      style = $urandom_range(0, 9);
      if (style <= 5) return SAMPLE_W'($urandom);
      if (style == 6) return pick_extreme();
      if (style <= 8) return SAMPLE_W'($urandom_range(0, 512) - 256);
      if ($urandom_range(0, 1)) return S_MAX - SAMPLE_W'($urandom_range(0, 15));
      return S_MIN + SAMPLE_W'($urandom_range(0, 15));
   endfunction

   // one sample transaction; opens a gap between bursts when idling is on
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      int gap;
      if (sender_gap_max > 0 && burst_left == 0) begin
         gap = $urandom_range(1, sender_gap_max);
         burst_left = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (!req_ready);
      run_filter_model(value);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_coef(input logic [INDEX_W-1:0] index, input logic [COEF_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index < COEF_COUNT) coef_model[index] = value;
   endtask

   task automatic load_coef_set(input coef_set_t kind);
      logic [COEF_W-1:0] value;
      int hot;
      hot = $urandom_range(0, COEF_COUNT - 1);
      for (int i = 0; i < COEF_COUNT; i++) begin
         case (kind)
            COEFS_DEFAULT: begin
               case (reg_index_type'(i))
                  REG_OUTER: value = OUTER_RESET;
                  REG_FAR:   value = FAR_RESET;
                  REG_MID:   value = MID_RESET;
                  REG_NEAR:  value = NEAR_RESET;
                  default:   value = CENTRE_RESET;
               endcase
            end
            COEFS_EXTREME: value = pick_extreme();
            COEFS_RANDOM:  value = COEF_W'($urandom);
            COEFS_SMALL:   value = COEF_W'($urandom_range(0, 4096) - 2048);
            COEFS_SINGLE:  value = (i == hot) ? COEF_W'($urandom) : '0;
            COEFS_ALL_MAX: value = S_MAX;
            default:       value = S_MIN;
         endcase
         write_coef(INDEX_W'(i), value);
      end
   endtask

   task automatic set_idling(input int gap_max, input ready_mode_t mode);
      sender_gap_max = gap_max;
      burst_left = 0;
      ready_mode <= mode;
      ready_mask <= 8'($urandom) | 8'h01;
   endtask

   // warmup, first output with zeros on the older side, field extremes
   task automatic test_warmup_and_edges();
      set_idling(0, READY_ALWAYS);
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample('0);
      send_sample('1);
      send_sample(SAMPLE_W'(1));
      send_sample(16'h5555);
      send_sample(16'haaaa);
      send_sample(S_MAX);
      send_sample(S_MIN);
      wait_drained();
   endtask

   // full-scale coefficients drive the sum past both output limits
   task automatic test_saturation();
      set_idling(3, READY_MASK);
      load_coef_set(COEFS_ALL_MAX);
      write_coef(IDX_SPARE_FIRST, '0);
      repeat (4) send_sample(S_MAX);
      wait_drained();
      load_coef_set(COEFS_ALL_MIN);
      write_coef(IDX_SPARE_LAST, COEF_W'($urandom));
      repeat (4) send_sample(S_MAX);
      repeat (4) send_sample(S_MIN);
      wait_drained();
   endtask

   task automatic test_random_stream();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_idling((p % 3 == 0) ? 0 : $urandom_range(2, 12), ready_mode_t'(p % 4));
         load_coef_set(coef_set_t'(p % 5));
         if ($urandom_range(0, 1)) begin
            write_coef(INDEX_W'($urandom_range(IDX_SPARE_FIRST, IDX_SPARE_LAST)),
                       COEF_W'($urandom));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2 && (p == 0 || $urandom_range(0, 1))) wait_drained();
            send_sample(pick_sample());
         end
         wait_drained();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
            READY_MASK:   rsp_ready <= ready_mask[ready_step];
            default: begin
               if (ready_run == 0) begin
                  ready_hold = !ready_hold;
                  ready_run = ready_hold ? $urandom_range(1, 20) : $urandom_range(1, 30);
               end
               ready_run--;
               rsp_ready <= ready_hold;
            end
         endcase
         ready_step <= ready_step + 3'd1;
      end
   end

   // output checker
   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            report_mismatch("output transaction with none expected", rsp_filtered_out, '0);
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_filtered_out !== want) begin
               report_mismatch("filtered_out", rsp_filtered_out, want);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("** halfband_decimator_q15: FAILED **");
         $finish;
      end
   end

   initial begin
      foreach (taps[i]) taps[i] = '0;
      coef_model[REG_OUTER]  = OUTER_RESET;
      coef_model[REG_FAR]    = FAR_RESET;
      coef_model[REG_MID]    = MID_RESET;
      coef_model[REG_NEAR]   = NEAR_RESET;
      coef_model[REG_CENTRE] = CENTRE_RESET;
      warm_count = '0;
      odd_phase = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_warmup_and_edges();
      test_saturation();
      test_random_stream();
      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** halfband_decimator_q15: PASSED **");
      end else begin
         $display("** halfband_decimator_q15: FAILED **");
      end
      $finish;
   end

endmodule
